@@ rtl/core/srs_pkg.sv @@
// Package for the sensor range statistics block.
// Holds store sizing, command and status codes, word and task types.
// No dependencies; every module of the block imports it.
`timescale 1ns / 1ps

package srs_pkg;

    // Store capacity and the widths that follow from it.
    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int SUM_W       = 16 + CNT_W;
    localparam int STEP_W      = $clog2(SUM_W + 1);

    // Command codes.
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_WALK,
        B_FIN,
        B_DIV,
        B_OUT
    } back_state_t;

    typedef struct packed {
        logic               command;
        logic signed [15:0] sample;
        logic [9:0]         left_index;
        logic [10:0]        right_index;
    } in_word_t;

    typedef struct packed {
        status_t            status;
        logic signed [15:0] min_value;
        logic signed [15:0] max_value;
        logic signed [15:0] mean_value;
        logic [10:0]        valid_count;
        logic signed [15:0] point_value;
        logic [10:0]        stored_count;
    } out_word_t;

    // Work item handed from the front end to the back end.
    typedef struct packed {
        logic               is_query;
        logic               full;        // append dropped
        logic               point_ok;    // left index below fill count
        logic signed [15:0] sample;
        logic [ADDR_W-1:0]  pos;         // append write position or point read position
        logic [CNT_W-1:0]   walk_start;
        logic [CNT_W-1:0]   end_pos;
        logic [CNT_W-1:0]   fill_after;
    } task_t;

    // End of the walked range: min(right, fill).
    function automatic logic [CNT_W-1:0] range_end(input logic [10:0] right,
                                                   input logic [CNT_W-1:0] fill);
        logic [CNT_W-1:0] res;
        if (32'(right) < 32'(fill))
        begin
            res = CNT_W'(right);
        end
        else
        begin
            res = fill;
        end
        return res;
    endfunction

endpackage

@@ rtl/core/srs_queue.sv @@
// Two-entry task queue between the front end and the back end.
// Depends on srs_pkg for task_t.
`timescale 1ns / 1ps

module srs_queue
    import srs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  task_t push_task,
    input  logic  pop,
    output task_t head,
    output logic  full,
    output logic  empty
);

    task_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_task;
        end
    end

endmodule

@@ rtl/core/srs_front.sv @@
// Front end: accepts input words, owns the fill count and classifies each
// word into a back-end task. Depends on srs_pkg.
`timescale 1ns / 1ps

module srs_front
    import srs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_stall,
    input  in_word_t item,
    input  logic     q_full,
    output logic     q_push,
    output task_t    q_task
);

    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic [CNT_W-1:0] end_pos;
    logic             is_full;

    assign item_stall = q_full;
    assign q_push     = item_valid && !q_full;
    assign end_pos    = range_end(item.right_index, fill_reg);
    assign is_full    = (32'(fill_reg) >= 32'(STORE_DEPTH));

    always_comb
    begin
        fill_next = fill_reg;
        q_task    = '0;
        q_task.sample   = item.sample;
        q_task.end_pos  = end_pos;
        q_task.point_ok = (32'(item.left_index) < 32'(fill_reg));
        if (item.command == CMD_QUERY)
        begin
            q_task.is_query = 1'b1;
            q_task.pos      = ADDR_W'(item.left_index);
            if (32'(item.left_index) < 32'(end_pos))
            begin
                q_task.walk_start = CNT_W'(item.left_index);
            end
            else
            begin
                q_task.walk_start = end_pos;
            end
        end
        else
        begin
            q_task.is_query = 1'b0;
            q_task.full     = is_full;
            q_task.pos      = fill_reg[ADDR_W-1:0];
            if (!is_full)
            begin
                fill_next = fill_reg + CNT_W'(1);
            end
        end
        q_task.fill_after = fill_next;
        if (!q_push)
        begin
            fill_next = fill_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

endmodule

@@ rtl/core/srs_div.sv @@
// Serial signed divider: sum over count, truncated toward zero.
// One quotient bit per cycle. Depends on srs_pkg.
`timescale 1ns / 1ps

module srs_div
    import srs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0]        divisor,
    output logic                    done,
    output logic signed [15:0]      quotient
);

    logic [SUM_W-1:0]  quo_reg;
    logic [SUM_W-1:0]  quo_next;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  rem_next;
    logic [CNT_W-1:0]  dsr_reg;
    logic [CNT_W-1:0]  dsr_next;
    logic              neg_reg;
    logic              neg_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [CNT_W:0]    shifted;
    logic [SUM_W-1:0]  signed_quo;

    assign shifted    = {rem_reg, quo_reg[SUM_W-1]};
    assign signed_quo = neg_reg ? (~quo_reg + SUM_W'(1)) : quo_reg;
    assign quotient   = signed_quo[15:0];
    assign done       = done_reg;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            neg_next  = dividend[SUM_W-1];
            quo_next  = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            step_next = STEP_W'(SUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_next = CNT_W'(shifted - {1'b0, dsr_reg});
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[CNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        neg_reg  <= neg_next;
        step_reg <= step_next;
    end

endmodule

@@ rtl/core/srs_back.sv @@
// Back end: holds the sample store, executes appends and walks query ranges,
// then divides for the mean and drives the result register.
// Depends on srs_pkg and srs_div.
`timescale 1ns / 1ps

module srs_back
    import srs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic signed [15:0] invalid_code,
    input  logic               q_empty,
    input  task_t              q_head,
    output logic               q_pop,
    output logic               result_valid,
    input  logic               result_stall,
    output out_word_t          result
);

    logic signed [15:0] mem [STORE_DEPTH];
    logic signed [15:0] rd_data_reg;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;

    back_state_t        state_reg;
    back_state_t        state_next;
    logic               valid_reg;
    logic               valid_next;
    logic               rd_first_reg;
    logic               rd_first_next;
    logic               rd_stat_reg;
    logic               rd_stat_next;

    task_t              cur_reg;
    task_t              cur_next;
    out_word_t          result_reg;
    out_word_t          result_next;
    logic [CNT_W-1:0]   addr_reg;
    logic [CNT_W-1:0]   addr_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [15:0] min_reg;
    logic signed [15:0] min_next;
    logic signed [15:0] max_reg;
    logic signed [15:0] max_next;
    logic signed [15:0] point_reg;
    logic signed [15:0] point_next;

    logic               div_start;
    logic               div_done;
    logic signed [15:0] div_quotient;

    srs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign result_valid = valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        rd_first_next = 1'b0;
        rd_stat_next  = 1'b0;
        cur_next      = cur_reg;
        result_next   = result_reg;
        addr_next     = addr_reg;
        cnt_next      = cnt_reg;
        sum_next      = sum_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        point_next    = point_reg;
        q_pop         = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        div_start     = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_head;
                    if (q_head.is_query)
                    begin
                        rd_en         = 1'b1;
                        rd_addr       = q_head.pos;
                        rd_first_next = 1'b1;
                        addr_next     = q_head.walk_start;
                        cnt_next      = '0;
                        sum_next      = '0;
                        state_next    = B_WALK;
                    end
                    else
                    begin
                        wr_en                    = !q_head.full;
                        result_next.status       = q_head.full ? ST_FULL : ST_OK;
                        result_next.min_value    = invalid_code;
                        result_next.max_value    = invalid_code;
                        result_next.mean_value   = invalid_code;
                        result_next.valid_count  = '0;
                        result_next.point_value  = invalid_code;
                        result_next.stored_count = 11'(q_head.fill_after);
                        valid_next               = 1'b1;
                        state_next               = B_OUT;
                    end
                end
            end
            B_WALK:
            begin
                if (rd_first_reg)
                begin
                    point_next = cur_reg.point_ok ? rd_data_reg : invalid_code;
                end
                if (rd_stat_reg && (rd_data_reg != invalid_code))
                begin
                    if ((cnt_reg == '0) || (rd_data_reg < min_reg))
                    begin
                        min_next = rd_data_reg;
                    end
                    if ((cnt_reg == '0) || (rd_data_reg > max_reg))
                    begin
                        max_next = rd_data_reg;
                    end
                    sum_next = sum_reg + SUM_W'(rd_data_reg);
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (addr_reg < cur_reg.end_pos)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = addr_reg[ADDR_W-1:0];
                    rd_stat_next = 1'b1;
                    addr_next    = addr_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = B_FIN;
                end
            end
            B_FIN:
            begin
                result_next.point_value  = point_reg;
                result_next.stored_count = 11'(cur_reg.fill_after);
                result_next.valid_count  = 11'(cnt_reg);
                if (cnt_reg == '0)
                begin
                    result_next.status     = ST_EMPTY;
                    result_next.min_value  = invalid_code;
                    result_next.max_value  = invalid_code;
                    result_next.mean_value = invalid_code;
                    valid_next             = 1'b1;
                    state_next             = B_OUT;
                end
                else
                begin
                    result_next.status    = ST_OK;
                    result_next.min_value = min_reg;
                    result_next.max_value = max_reg;
                    div_start             = 1'b1;
                    state_next            = B_DIV;
                end
            end
            B_DIV:
            begin
                if (div_done)
                begin
                    result_next.mean_value = div_quotient;
                    valid_next             = 1'b1;
                    state_next             = B_OUT;
                end
            end
            B_OUT:
            begin
                if (!result_stall)
                begin
                    valid_next = 1'b0;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                valid_next = 1'b0;
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            valid_reg    <= 1'b0;
            rd_first_reg <= 1'b0;
            rd_stat_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            rd_first_reg <= rd_first_next;
            rd_stat_reg  <= rd_stat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        result_reg <= result_next;
        addr_reg   <= addr_next;
        cnt_reg    <= cnt_next;
        sum_reg    <= sum_next;
        min_reg    <= min_next;
        max_reg    <= max_next;
        point_reg  <= point_next;
    end

    // Sample store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[q_head.pos] <= q_head.sample;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/core/sensor_range_statistics_top.sv @@
// Top level of the sensor range statistics block.
// Depends on srs_pkg, srs_front, srs_queue and srs_back.
`timescale 1ns / 1ps

// The block keeps an append-only store of STORE_DEPTH signed Q12.4 samples
// and answers range queries on it. An append word stores its sample, or
// drops it with status full when the store is at capacity. A query word
// walks positions left_index up to min(right_index, stored count) - 1
// through the single read port of the sample store, one position per
// cycle, skipping samples equal to the invalid code, and then divides the
// sum by the valid count in a serial divider that produces one quotient
// bit per cycle; a range with no valid sample skips the division. The
// front end accepts words into a two-entry queue while the back end is
// busy, so input words keep flowing until the queue fills. A finished
// result waits in the output register until it is taken, and the back
// end starts no new task meanwhile, so a stalled result stalls the input
// once the queue is full. The invalid code register is written through
// the configuration channel, which is always ready; write it only while
// the block is idle. The store needs no clearing after reset: only
// positions below the stored count are ever read for statistics.
module sensor_range_statistics_top
    import srs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic signed [15:0] cfg_data,
    input  logic               item_valid,
    output logic               item_stall,
    input  in_word_t           item,
    output logic               result_valid,
    input  logic               result_stall,
    output out_word_t          result
);

    logic signed [15:0] invalid_code_reg;
    logic signed [15:0] invalid_code_next;
    logic               q_full;
    logic               q_empty;
    logic               q_push;
    logic               q_pop;
    task_t              q_task;
    task_t              q_head;

    // The configuration write is taken in any cycle.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        invalid_code_next = invalid_code_reg;
        if (cfg_valid && cfg_ready)
        begin
            invalid_code_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invalid_code_reg <= 16'sh8000;
        end
        else
        begin
            invalid_code_reg <= invalid_code_next;
        end
    end

    // Front end: accepts words and turns them into tasks.
    srs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_task     (q_task)
    );

    // Decoupling queue between the two halves.
    srs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_task (q_task),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Back end: store, range walk, divider and result register.
    srs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .invalid_code (invalid_code_reg),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

@@ rtl/core/srs_checker.sv @@
// Port-level checker for the sensor range statistics block, bound to the top.
// Depends on srs_pkg and sensor_range_statistics_top.
`timescale 1ns / 1ps

module srs_checker
    import srs_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic signed [15:0] cfg_data,
    input logic               item_valid,
    input logic               item_stall,
    input in_word_t           item,
    input logic               result_valid,
    input logic               result_stall,
    input out_word_t          result
);

    // A stalled result word holds.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // A dropped append carries no statistics.
    a_full_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == ST_FULL) |->
            (result.valid_count == 11'd0) && (result.min_value == result.max_value))
        else $error("dropped append reports statistics");

    // An empty range reports zero count and one value, the invalid code, in min, max and mean.
    a_empty_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == ST_EMPTY) |->
            (result.valid_count == 11'd0) && (result.min_value == result.max_value) &&
            (result.mean_value == result.min_value))
        else $error("empty range result inconsistent");

    // The mean of a non-empty range lies between its minimum and maximum.
    a_mean_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == ST_OK) && (result.valid_count != 11'd0) |->
            (result.min_value <= result.mean_value) &&
            (result.mean_value <= result.max_value))
        else $error("mean outside min and max");

    // The store never reports more samples than it can hold.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (32'(result.stored_count) <= 32'(STORE_DEPTH)))
        else $error("stored count beyond capacity");

endmodule

bind sensor_range_statistics_top srs_checker u_srs_checker (.*);

@@ dv/tb_sensor_range_statistics_top.sv @@
// Self-checking testbench for sensor_range_statistics_top.
// Depends on srs_pkg for the word types, the command and status codes and the store depth.
`timescale 1ns / 1ps

// The testbench drives append and query words into the block and checks
// every result word against its own prediction of the block. The prediction
// keeps a copy of the sample store, the fill count and the invalid code. Each
// word is predicted at the clock edge where the block accepts it, and the
// expected result goes to the back of a queue. A checking process compares
// every accepted result word, field by field, with the front of that queue.
//
// The run has these parts:
//   - a directed part with the extreme samples, an empty store, ranges that
//     hold only invalid samples, an inverted range and reads past the fill,
//   - random traffic in three idling phases: the sender idles rarely and the
//     receiver often, then the other way round, then neither idles,
//   - a back-pressure part, where the receiver holds off for a long stretch
//     while the sender keeps offering words, so the block's input queue fills,
//   - a part that queries long ranges over everything stored so far.
// The invalid code register is rewritten between parts, only once every
// expected result has come back, and it goes through both extremes.
module tb_sensor_range_statistics_top;
    import srs_pkg::*;

    // A stretch with no accepted word longer than this ends the run. The
    // longest correct stretch is a full-store query behind the receiver's
    // long hold-off, or the final quiet wait.
    localparam int QUIET_LIMIT   = 20000;
    // Cycles to let pass once nothing is pending, before a register write.
    localparam int SETTLE_CYCLES = 8;
    // Cycles to watch for stray results at the end, above the longest query.
    localparam int TAIL_CYCLES   = 1200;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid  = 1'b0;
    logic               cfg_ready;
    logic signed [15:0] cfg_data   = '0;
    logic               item_valid = 1'b0;
    logic               item_stall;
    in_word_t           item       = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    out_word_t          result;

    // Idling percentages for the sender and the receiver, and a request for
    // the receiver to hold off for a number of cycles.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_req  = 0;

    int mismatch_count = 0;
    int results_seen   = 0;

    // The testbench's own copy of the block state.
    logic signed [15:0] shadow_samples [STORE_DEPTH];
    int                 shadow_fill = 0;
    logic signed [15:0] shadow_code = 16'sh8000;

    // Expected result words, oldest first.
    out_word_t pending_stats [$];

    sensor_range_statistics_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Works out the result word for one accepted word and updates the copy
    // of the store. A query walks left_index up to min(right_index, fill)
    // minus one, skipping samples equal to the invalid code. The mean
    // truncates toward zero, which is what signed division in SystemVerilog
    // does.
    function automatic out_word_t predict_stats(input in_word_t w);
        out_word_t          r;
        logic signed [15:0] lowest;
        logic signed [15:0] highest;
        logic signed [15:0] s;
        longint             total;
        int                 last;
        int                 n;
        r = '0;
        r.status      = ST_OK;
        lowest        = shadow_code;
        highest       = shadow_code;
        r.mean_value  = shadow_code;
        r.point_value = shadow_code;
        n = 0;
        total = 0;
        if (w.command == CMD_APPEND)
        begin
            if (shadow_fill < STORE_DEPTH)
            begin
                shadow_samples[shadow_fill] = w.sample;
                shadow_fill++;
            end
            else
                r.status = ST_FULL;
        end
        else
        begin
            last = (int'(w.right_index) < shadow_fill) ? int'(w.right_index) : shadow_fill;
            for (int i = int'(w.left_index); i < last; i++)
            begin
                s = shadow_samples[i];
                if (s == shadow_code)
                    continue;
                if (n == 0 || s < lowest)
                    lowest = s;
                if (n == 0 || s > highest)
                    highest = s;
                total += s;
                n++;
            end
            if (n == 0)
            begin
                // No valid sample: min, max and mean fall back to the invalid code;
                // the point read and the fill count do not.
                r.status = ST_EMPTY;
                lowest   = shadow_code;
                highest  = shadow_code;
            end
            else
                r.mean_value = 16'(total / n);
            // A stored sample is returned as it is, even if it equals the
            // invalid code.
            if (int'(w.left_index) < shadow_fill)
                r.point_value = shadow_samples[w.left_index];
        end
        r.min_value    = lowest;
        r.max_value    = highest;
        r.valid_count  = 11'(n);
        r.stored_count = 11'(shadow_fill);
        return r;
    endfunction

    // One line per failure, and a count.
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    // Checks each accepted result word against the oldest expectation.
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_stats.size() == 0)
                report_mismatch("result word with no expectation pending");
            else
            begin
                want = pending_stats.pop_front();
                check_field("status", 16'(result.status), 16'(want.status));
                check_field("min_value", result.min_value, want.min_value);
                check_field("max_value", result.max_value, want.max_value);
                check_field("mean_value", result.mean_value, want.mean_value);
                check_field("valid_count", 16'(result.valid_count), 16'(want.valid_count));
                check_field("point_value", result.point_value, want.point_value);
                check_field("stored_count", 16'(result.stored_count),
                            16'(want.stored_count));
            end
            results_seen++;
        end
    end

    // The receiver stalls at random at the current rate, or holds off
    // without a break for as many cycles as the last request asked.
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req > 0)
            begin
                hold_left    = hold_off_req;
                hold_off_req = 0;
            end
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else
                result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Ends the run if no word moves on any channel for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // Offers one word, idling first at the sender's rate, and records the
    // expected result at the edge where the word is taken. The valid stays
    // high on return, so back-to-back words need no gap; the next call, when
    // it idles, or wait_idle lowers it.
    task automatic send_word(input in_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item       <= w;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        pending_stats.insert(pending_stats.size(), predict_stats(w));
    endtask

    // Stops offering words and waits until every expected result is in.
    task automatic wait_idle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the invalid code while the block has nothing to do.
    task automatic write_invalid_code(input logic signed [15:0] code);
        wait_idle();
        cfg_data  <= code;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        shadow_code = code;
    endtask

    function automatic in_word_t make_word(input logic cmd, input logic signed [15:0] sample,
                                           input int left, input int right);
        in_word_t w;
        w.command     = cmd;
        w.sample      = sample;
        w.left_index  = 10'(left);
        w.right_index = 11'(right);
        return w;
    endfunction

    // Samples lean toward the invalid code and the extremes, so that
    // skipped samples and range edges are common.
    function automatic logic signed [15:0] pick_sample();
        logic signed [15:0] s;
        case ($urandom_range(19))
            0, 1, 2: s = shadow_code;
            3:       s = 16'sh8000;
            4:       s = 16'sh7FFF;
            5:       s = 16'($urandom_range(32)) - 16'sd16;
            default: s = 16'($urandom);
        endcase
        return s;
    endfunction

    // A random word. Most queries cover short ranges inside the stored
    // samples; some use fully random indexes (often empty ranges), some run
    // to the top of the index range, and some walk the whole store.
    function automatic in_word_t random_word(input int append_pct);
        in_word_t w;
        int       lo;
        int       hi;
        int       shape;
        w = make_word(CMD_APPEND, pick_sample(), $urandom_range(1023), $urandom_range(1024));
        if ($urandom_range(99) >= append_pct)
        begin
            w.command = CMD_QUERY;
            shape = $urandom_range(99);
            lo = (shadow_fill > 0) ? $urandom_range(shadow_fill - 1) : 0;
            if (shape < 70)
                hi = lo + $urandom_range(64);
            else if (shape < 80)
            begin
                lo = w.left_index;
                hi = w.right_index;
            end
            else if (shape < 90)
                hi = 1024;
            else
            begin
                lo = 0;
                hi = shadow_fill + $urandom_range(2);
            end
            if (hi > 1024)
                hi = 1024;
            w.left_index  = 10'(lo);
            w.right_index = 11'(hi);
        end
        return w;
    endfunction

    // Empty store, the extreme samples, a range holding only an invalid
    // sample, an inverted range, point reads past the fill, and a mean that
    // must truncate toward zero for negative sums.
    task automatic test_directed_cases();
        send_word(make_word(CMD_QUERY, 16'sh0000, 0, 0));
        send_word(make_word(CMD_QUERY, 16'sh7FFF, 1023, 1024));
        send_word(make_word(CMD_APPEND, 16'sh8000, 0, 0));
        // Position 0 holds the invalid code: nothing valid, point read as is.
        send_word(make_word(CMD_QUERY, 16'sh0000, 0, 1));
        send_word(make_word(CMD_APPEND, 16'sh7FFF, 1023, 1024));
        send_word(make_word(CMD_APPEND, 16'sh8001, 0, 0));
        send_word(make_word(CMD_APPEND, 16'shFFFF, 0, 0));
        send_word(make_word(CMD_APPEND, 16'sh0000, 0, 0));
        send_word(make_word(CMD_APPEND, 16'sh0001, 0, 0));
        send_word(make_word(CMD_APPEND, 16'sh0010, 0, 0));
        send_word(make_word(CMD_QUERY, 16'sh0000, 0, 1024));
        send_word(make_word(CMD_QUERY, 16'sh0000, 1, 3));
        send_word(make_word(CMD_QUERY, 16'sh0000, 3, 4));
        // -32768 / 3 must give -10922, not -10923.
        send_word(make_word(CMD_QUERY, 16'sh0000, 2, 5));
        // -1 / 2 must give 0.
        send_word(make_word(CMD_QUERY, 16'sh0000, 3, 5));
        send_word(make_word(CMD_QUERY, 16'sh0000, 5, 2));
        send_word(make_word(CMD_QUERY, 16'sh0000, 7, 1024));
        send_word(make_word(CMD_QUERY, 16'sh0000, 6, 7));
        send_word(make_word(CMD_QUERY, 16'sh0000, 1023, 1024));
        send_word(make_word(CMD_QUERY, 16'sh5555, 1, 2));
    endtask

    task automatic test_random_traffic(input int count);
        for (int k = 0; k < count; k++)
            send_word(random_word(50));
    endtask

    // The receiver holds off for a long stretch while the sender offers
    // words without a gap, so the block's queue fills and it stalls its
    // input.
    task automatic test_backpressure();
        int saved_pct;
        saved_pct     = send_idle_pct;
        send_idle_pct = 0;
        hold_off_req  = 400;
        for (int k = 0; k < 12; k++)
            send_word(random_word(40));
        send_idle_pct = saved_pct;
    endtask

    // Queries long ranges over everything stored so far, under the current
    // invalid code and two newly written ones, with point reads on both sides of the fill.
    task automatic test_long_ranges();
        send_word(make_word(CMD_QUERY, 16'sh0000, 0, 1024));
        send_word(make_word(CMD_QUERY, 16'sh0000, 1023, 1024));
        send_word(make_word(CMD_QUERY, 16'sh0000, 0, 1023));
        send_word(make_word(CMD_QUERY, 16'sh0000, 512, 1024));
        for (int k = 0; k < 6; k++)
            send_word(random_word(30));
        // A code taken from the store, so some stored samples get skipped.
        write_invalid_code(shadow_fill > 0 ? shadow_samples[$urandom_range(shadow_fill - 1)]
                                           : 16'sh1234);
        send_word(make_word(CMD_QUERY, 16'sh0000, 0, 1024));
        for (int k = 0; k < 6; k++)
            send_word(random_word(30));
        write_invalid_code(16'sh7FFF);
        send_word(make_word(CMD_QUERY, 16'sh0000, 0, 1024));
        send_word(make_word(CMD_APPEND, pick_sample(), 0, 0));
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First phase: the sender rarely idles, the receiver often stalls.
        send_idle_pct = 7;
        recv_idle_pct = 59;
        write_invalid_code(16'sh8000);
        test_directed_cases();
        test_random_traffic(170);

        // Second phase: the other way round.
        write_invalid_code(16'sh7FFF);
        send_idle_pct = 59;
        recv_idle_pct = 7;
        test_backpressure();
        test_random_traffic(170);

        // Third phase: no idling on either side.
        write_invalid_code(16'sh0000);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(85);
        write_invalid_code(shadow_fill > 0 ? shadow_samples[$urandom_range(shadow_fill - 1)]
                                           : 16'sh1234);
        test_random_traffic(85);
        test_long_ranges();

        // Everything is sent; wait for the last results, then watch for
        // stray ones for longer than the longest query takes.
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sensor_range_statistics_top.f @@
rtl/core/srs_pkg.sv
rtl/core/srs_queue.sv
rtl/core/srs_front.sv
rtl/core/srs_div.sv
rtl/core/srs_back.sv
rtl/core/sensor_range_statistics_top.sv
rtl/core/srs_checker.sv
dv/tb_sensor_range_statistics_top.sv
